// ===== design/etm_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Euler TRS matrix builder.
// No dependencies; every other design file imports this package.
package etm_pkg;

	localparam int TRIG_FRAC = 30;

	// Pipeline depths of the three datapath parts
	localparam int SC_LAT  = 14;
	localparam int ROT_LAT = 4;
	localparam int AX_LAT  = 2;
	localparam int SCL_DLY = SC_LAT + ROT_LAT;
	localparam int ETM_LAT = SC_LAT + ROT_LAT + AX_LAT;

	// Angle units: 1/64 degree
	localparam logic signed [16:0] ANG_FULL    = 17'sd23040;
	localparam logic signed [16:0] ANG_2FULL   = 17'sd46080;
	localparam logic [14:0]        ANG_Q1      = 15'd5760;
	localparam logic [14:0]        ANG_Q2      = 15'd11520;
	localparam logic [14:0]        ANG_Q3      = 15'd17280;
	localparam logic [12:0]        ANG_QUARTER = 13'd5760;
	localparam logic [12:0]        ANG_EIGHTH  = 13'd2880;
	localparam logic [18:0]        RAD_PER_UNIT = 19'd292818;

	// Series divisors and their 2^32 reciprocals
	localparam logic [15:0] DIV_3 = 16'd6;
	localparam logic [15:0] DIV_4 = 16'd24;
	localparam logic [15:0] DIV_5 = 16'd120;
	localparam logic [15:0] DIV_6 = 16'd720;
	localparam logic [15:0] DIV_7 = 16'd5040;
	localparam logic [15:0] DIV_8 = 16'd40320;
	localparam logic [31:0] RCP_3 = 32'((64'd1 << 32) / 64'd6);
	localparam logic [31:0] RCP_4 = 32'((64'd1 << 32) / 64'd24);
	localparam logic [31:0] RCP_5 = 32'((64'd1 << 32) / 64'd120);
	localparam logic [31:0] RCP_6 = 32'((64'd1 << 32) / 64'd720);
	localparam logic [31:0] RCP_7 = 32'((64'd1 << 32) / 64'd5040);
	localparam logic [31:0] RCP_8 = 32'((64'd1 << 32) / 64'd40320);

	localparam logic signed [63:0] ROUND_HALF = 64'sd536870912;
	localparam logic signed [63:0] AXIS_MAX   = 64'sd8388607;
	localparam logic signed [63:0] AXIS_MIN   = -64'sd8388608;

	typedef logic [29:0]        pw_t;
	typedef logic signed [31:0] q30s_t;
	typedef logic signed [23:0] axis_t;

	typedef struct packed {
		logic signed [31:0] translation_x;
		logic signed [31:0] translation_y;
		logic signed [31:0] translation_z;
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
		logic signed [23:0] scale_x;
		logic signed [23:0] scale_y;
		logic signed [23:0] scale_z;
	} in_item_t;

	typedef struct packed {
		logic signed [23:0] axis_x_0;
		logic signed [23:0] axis_x_1;
		logic signed [23:0] axis_x_2;
		logic signed [23:0] axis_y_0;
		logic signed [23:0] axis_y_1;
		logic signed [23:0] axis_y_2;
		logic signed [23:0] axis_z_0;
		logic signed [23:0] axis_z_1;
		logic signed [23:0] axis_z_2;
		logic signed [31:0] pos_out_x;
		logic signed [31:0] pos_out_y;
		logic signed [31:0] pos_out_z;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} pos_t;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
	} scl_t;

	// Unsigned Q30 product, truncated
	function automatic pw_t qmul(input pw_t a, input pw_t b);
		logic [59:0] p;
		p = 60'(a) * 60'(b);
		return p[59:30];
	endfunction

	// Quotient estimate by reciprocal: exact or one low
	function automatic pw_t rcp_est(input pw_t v, input logic [31:0] rcp);
		logic [61:0] p;
		p = 62'(v) * 62'(rcp);
		return p[61:32];
	endfunction

	// Correct the estimate by one where the remainder reaches the divisor
	function automatic pw_t rcp_fix(input pw_t v, input pw_t e, input logic [15:0] d);
		logic [45:0] p;
		logic [30:0] rem;
		p   = 46'(e) * 46'(d);
		rem = {1'b0, v} - p[30:0];
		return (rem >= 31'(d)) ? pw_t'(e + 30'd1) : e;
	endfunction

	// floor((v + 2^29) / 2^30)
	function automatic logic signed [63:0] round_q30(input logic signed [63:0] v);
		return (v + ROUND_HALF) >>> TRIG_FRAC;
	endfunction

	function automatic axis_t sat_axis(input logic signed [63:0] v);
		if (v > AXIS_MAX) begin
			return 24'sh7fffff;
		end else if (v < AXIS_MIN) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

endpackage

// ===== design/etm_sincos.sv =====
// Pipelined sine/cosine of one angle in 1/64 degree units, Q30 results.
// Range reduction, truncated Taylor series, quadrant fold. Uses etm_pkg.
module etm_sincos import etm_pkg::*; (
	input  logic               clk,
	input  logic signed [15:0] ang,
	output q30s_t              sine,
	output q30s_t              cosine
);

	logic [14:0] r_s1;
	logic [1:0]  q_s2;
	logic [12:0] f_s2;
	logic [11:0] u_s3;
	logic [1:0]  q_d [3:13];
	logic        sw_d [3:13];
	pw_t x_s4, x_s5, x_s6, x_s7, x_s8, x_s9, x_s10, x_s11, x_s12;
	pw_t x2_s5, x2_s6, x2_s7, x2_s8, x2_s9;
	pw_t x3_s6, x3_s7, x4_s6, x4_s7;
	pw_t x4s_s7, x6_s7, x8_s7, x5_s8, x5_s9, x6s_s9, x6_s8, x8_s8, x7_s10, x7_s11;
	pw_t e3_s7, e4_s7, e6_s8, e8_s8, e5_s9, e7_s11;
	pw_t d3_s8, d3_s9, d3_s10, d3_s11, d3_s12, d4_s8, d4_s9;
	pw_t d6_s9, d8_s9, d5_s10, d5_s11, d5_s12, d7_s12;
	logic [30:0] cos_s10, cos_s11, cos_s12, cos_s13, sin_s13;
	q30s_t sine_s14, cosine_s14;

	logic signed [16:0] ae;
	logic signed [16:0] r_c;
	logic [30:0]        s0, c0;
	q30s_t              sv, cv;

	always_comb begin
		ae = 17'(ang);
		if (ae < -ANG_FULL) begin
			r_c = ae + ANG_2FULL;
		end else if (ae < 17'sd0) begin
			r_c = ae + ANG_FULL;
		end else if (ae >= ANG_FULL) begin
			r_c = ae - ANG_FULL;
		end else begin
			r_c = ae;
		end
		s0 = sw_d[13] ? cos_s13 : sin_s13;
		c0 = sw_d[13] ? sin_s13 : cos_s13;
		sv = $signed({1'b0, s0});
		cv = $signed({1'b0, c0});
	end

	always_ff @(posedge clk) begin
		// reduce to one turn, then to a quadrant and an offset
		r_s1 <= r_c[14:0];
		if (r_s1 >= ANG_Q3) begin
			q_s2 <= 2'd3;
			f_s2 <= 13'(r_s1 - ANG_Q3);
		end else if (r_s1 >= ANG_Q2) begin
			q_s2 <= 2'd2;
			f_s2 <= 13'(r_s1 - ANG_Q2);
		end else if (r_s1 >= ANG_Q1) begin
			q_s2 <= 2'd1;
			f_s2 <= 13'(r_s1 - ANG_Q1);
		end else begin
			q_s2 <= 2'd0;
			f_s2 <= r_s1[12:0];
		end
		if (f_s2 > ANG_EIGHTH) begin
			u_s3     <= 12'(ANG_QUARTER - f_s2);
			sw_d[3]  <= 1'b1;
		end else begin
			u_s3     <= f_s2[11:0];
			sw_d[3]  <= 1'b0;
		end
		q_d[3] <= q_s2;
		for (int i = 4; i <= 13; i++) begin
			q_d[i]  <= q_d[i-1];
			sw_d[i] <= sw_d[i-1];
		end

		// powers of x
		x_s4   <= 30'(31'(u_s3) * 31'(RAD_PER_UNIT));
		x_s5   <= x_s4;
		x2_s5  <= qmul(x_s4, x_s4);
		x_s6   <= x_s5;
		x2_s6  <= x2_s5;
		x3_s6  <= qmul(x2_s5, x_s5);
		x4_s6  <= qmul(x2_s5, x2_s5);
		x_s7   <= x_s6;
		x2_s7  <= x2_s6;
		x3_s7  <= x3_s6;
		x4_s7  <= x4_s6;
		x4s_s7 <= qmul(x3_s6, x_s6);
		x6_s7  <= qmul(x4_s6, x2_s6);
		x8_s7  <= qmul(x4_s6, x4_s6);
		e3_s7  <= rcp_est(x3_s6, RCP_3);
		e4_s7  <= rcp_est(x4_s6, RCP_4);
		x_s8   <= x_s7;
		x2_s8  <= x2_s7;
		x5_s8  <= qmul(x4s_s7, x_s7);
		d3_s8  <= rcp_fix(x3_s7, e3_s7, DIV_3);
		d4_s8  <= rcp_fix(x4_s7, e4_s7, DIV_4);
		x6_s8  <= x6_s7;
		x8_s8  <= x8_s7;
		e6_s8  <= rcp_est(x6_s7, RCP_6);
		e8_s8  <= rcp_est(x8_s7, RCP_8);
		x_s9   <= x_s8;
		x2_s9  <= x2_s8;
		x5_s9  <= x5_s8;
		x6s_s9 <= qmul(x5_s8, x_s8);
		e5_s9  <= rcp_est(x5_s8, RCP_5);
		d3_s9  <= d3_s8;
		d4_s9  <= d4_s8;
		d6_s9  <= rcp_fix(x6_s8, e6_s8, DIV_6);
		d8_s9  <= rcp_fix(x8_s8, e8_s8, DIV_8);
		x_s10  <= x_s9;
		x7_s10 <= qmul(x6s_s9, x_s9);
		d3_s10 <= d3_s9;
		d5_s10 <= rcp_fix(x5_s9, e5_s9, DIV_5);
		cos_s10 <= 31'(32'h4000_0000 - 32'(x2_s9 >> 1) + 32'(d4_s9) - 32'(d6_s9)
			+ 32'(d8_s9));
		x_s11  <= x_s10;
		x7_s11 <= x7_s10;
		e7_s11 <= rcp_est(x7_s10, RCP_7);
		d3_s11 <= d3_s10;
		d5_s11 <= d5_s10;
		cos_s11 <= cos_s10;
		x_s12  <= x_s11;
		d7_s12 <= rcp_fix(x7_s11, e7_s11, DIV_7);
		d3_s12 <= d3_s11;
		d5_s12 <= d5_s11;
		cos_s12 <= cos_s11;
		sin_s13 <= 31'(32'(x_s12) - 32'(d3_s12) + 32'(d5_s12) - 32'(d7_s12));
		cos_s13 <= cos_s12;

		// fold back by quadrant
		case (q_d[13])
			2'd1: begin
				sine_s14   <= cv;
				cosine_s14 <= -sv;
			end
			2'd2: begin
				sine_s14   <= -sv;
				cosine_s14 <= -cv;
			end
			2'd3: begin
				sine_s14   <= -cv;
				cosine_s14 <= sv;
			end
			default: begin
				sine_s14   <= sv;
				cosine_s14 <= cv;
			end
		endcase
	end

	assign sine   = sine_s14;
	assign cosine = cosine_s14;

endmodule

// ===== design/etm_rot.sv =====
// Rotation matrix R = Rz*Ry*Rx in Q30 from three sine/cosine pairs, four stages.
// Column-major output m[0..8]. Uses etm_pkg.
module etm_rot import etm_pkg::*; (
	input  logic         clk,
	input  q30s_t        sx,
	input  q30s_t        cx,
	input  q30s_t        sy,
	input  q30s_t        cy,
	input  q30s_t        sz,
	input  q30s_t        cz,
	output q30s_t [8:0]  m
);

	logic signed [63:0] cycz_s1, cysz_s1, sxsy_s1, sxcy_s1, cxsy_s1, cxcy_s1;
	q30s_t sx_s1, cx_s1, sy_s1, sz_s1, cz_s1;
	q30s_t t1_s2, t2_s2, sx_s2, cx_s2, sz_s2, cz_s2;
	q30s_t m0_s2, m1_s2, m2_s2, m5_s2, m8_s2;
	logic signed [63:0] a_s3, b_s3, c_s3, d_s3, e_s3, f_s3, g_s3, h_s3;
	q30s_t m0_s3, m1_s3, m2_s3, m5_s3, m8_s3;
	q30s_t [8:0] m_s4;

	always_ff @(posedge clk) begin
		cycz_s1 <= 64'(cy) * 64'(cz);
		cysz_s1 <= 64'(cy) * 64'(sz);
		sxsy_s1 <= 64'(sx) * 64'(sy);
		sxcy_s1 <= 64'(sx) * 64'(cy);
		cxsy_s1 <= 64'(cx) * 64'(sy);
		cxcy_s1 <= 64'(cx) * 64'(cy);
		sx_s1 <= sx;
		cx_s1 <= cx;
		sy_s1 <= sy;
		sz_s1 <= sz;
		cz_s1 <= cz;

		m0_s2 <= 32'(round_q30(cycz_s1));
		m1_s2 <= 32'(round_q30(cysz_s1));
		m2_s2 <= -sy_s1;
		t1_s2 <= 32'(round_q30(sxsy_s1));
		m5_s2 <= 32'(round_q30(sxcy_s1));
		t2_s2 <= 32'(round_q30(cxsy_s1));
		m8_s2 <= 32'(round_q30(cxcy_s1));
		sx_s2 <= sx_s1;
		cx_s2 <= cx_s1;
		sz_s2 <= sz_s1;
		cz_s2 <= cz_s1;

		a_s3 <= 64'(t1_s2) * 64'(cz_s2);
		b_s3 <= 64'(cx_s2) * 64'(sz_s2);
		c_s3 <= 64'(t1_s2) * 64'(sz_s2);
		d_s3 <= 64'(cx_s2) * 64'(cz_s2);
		e_s3 <= 64'(t2_s2) * 64'(cz_s2);
		f_s3 <= 64'(sx_s2) * 64'(sz_s2);
		g_s3 <= 64'(t2_s2) * 64'(sz_s2);
		h_s3 <= 64'(sx_s2) * 64'(cz_s2);
		m0_s3 <= m0_s2;
		m1_s3 <= m1_s2;
		m2_s3 <= m2_s2;
		m5_s3 <= m5_s2;
		m8_s3 <= m8_s2;

		// sum before rounding
		m_s4[0] <= m0_s3;
		m_s4[1] <= m1_s3;
		m_s4[2] <= m2_s3;
		m_s4[3] <= 32'(round_q30(a_s3 - b_s3));
		m_s4[4] <= 32'(round_q30(c_s3 + d_s3));
		m_s4[5] <= m5_s3;
		m_s4[6] <= 32'(round_q30(e_s3 + f_s3));
		m_s4[7] <= 32'(round_q30(g_s3 - h_s3));
		m_s4[8] <= m8_s3;
	end

	assign m = m_s4;

endmodule

// ===== design/etm_axis.sv =====
// Scale the rotation columns: multiply, round from Q30, saturate to 24 bits.
// Two stages. Uses etm_pkg.
module etm_axis import etm_pkg::*; (
	input  logic        clk,
	input  q30s_t [8:0] m,
	input  scl_t        scl,
	output axis_t [8:0] axis
);

	logic signed [55:0] p_s1 [9];
	axis_t [8:0]        axis_s2;
	logic signed [23:0] sv [3];

	always_comb begin
		sv[0] = scl.x;
		sv[1] = scl.y;
		sv[2] = scl.z;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 9; i++) begin
			p_s1[i]    <= 56'(sv[i/3]) * 56'($signed(m[i]));
			axis_s2[i] <= sat_axis(round_q30(64'(p_s1[i])));
		end
	end

	assign axis = axis_s2;

endmodule

// ===== design/euler_trs_matrix_builder.sv =====
// Top level of the Euler TRS matrix builder: three sine/cosine pipes, rotation, scaling.
// Depends on etm_pkg, etm_sincos, etm_rot and etm_axis.
//
// Usage:
//   Drive an item on "item" and raise start. The item is taken at the rising edge
//   where start is high and busy is low; busy stays low, so an item may enter on
//   every cycle and one result leaves per cycle.
//   Each result appears on "result" for exactly one cycle, marked by done. An item
//   passes through angle reduction and series evaluation, then the matrix products,
//   then scaling and saturation. Results leave in the order items entered.
//   The receiver cannot stall; take the result in the cycle that done is high.
//   Reset clears the valid line only; items in flight at reset are dropped and
//   done stays low until new items arrive.
//   Outputs: the three scaled axis vectors of R = Rz*Ry*Rx (Q8.16, saturated)
//   and the translation passed through unchanged.
module euler_trs_matrix_builder import etm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      done,
	output out_item_t result
);

	logic        take;
	q30s_t       sx, cx, sy, cy, sz, cz;
	q30s_t [8:0] m;
	axis_t [8:0] ax;

	// valid and side payload travel alongside the datapath
	logic vld_s [ETM_LAT];
	pos_t pos_s [ETM_LAT];
	scl_t scl_s [SCL_DLY];

	assign busy = 1'b0;
	assign take = start && !busy;

	etm_sincos u_sc_x (.clk(clk), .ang(item.angle_x), .sine(sx), .cosine(cx));
	etm_sincos u_sc_y (.clk(clk), .ang(item.angle_y), .sine(sy), .cosine(cy));
	etm_sincos u_sc_z (.clk(clk), .ang(item.angle_z), .sine(sz), .cosine(cz));

	etm_rot u_rot (
		.clk(clk),
		.sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
		.m(m)
	);

	etm_axis u_axis (
		.clk(clk),
		.m(m),
		.scl(scl_s[SCL_DLY-1]),
		.axis(ax)
	);

	// advance the valid line; reset drops anything in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ETM_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[0] <= take;
			for (int i = 1; i < ETM_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// hold translation and scale until their rotation catches up
	always_ff @(posedge clk) begin
		pos_s[0] <= '{x: item.translation_x, y: item.translation_y, z: item.translation_z};
		for (int i = 1; i < ETM_LAT; i++) begin
			pos_s[i] <= pos_s[i-1];
		end
		scl_s[0] <= '{x: item.scale_x, y: item.scale_y, z: item.scale_z};
		for (int i = 1; i < SCL_DLY; i++) begin
			scl_s[i] <= scl_s[i-1];
		end
	end

	assign done = vld_s[ETM_LAT-1];

	always_comb begin
		result.axis_x_0  = ax[0];
		result.axis_x_1  = ax[1];
		result.axis_x_2  = ax[2];
		result.axis_y_0  = ax[3];
		result.axis_y_1  = ax[4];
		result.axis_y_2  = ax[5];
		result.axis_z_0  = ax[6];
		result.axis_z_1  = ax[7];
		result.axis_z_2  = ax[8];
		result.pos_out_x = pos_s[ETM_LAT-1].x;
		result.pos_out_y = pos_s[ETM_LAT-1].y;
		result.pos_out_z = pos_s[ETM_LAT-1].z;
	end

	// every accepted item comes out after exactly the pipeline depth
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##ETM_LAT done)
		else $error("item taken but no result after pipeline depth");

	// no result without an item taken the pipeline depth earlier
	a_nospur: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, ETM_LAT))
		else $error("result without matching item");

	// a zero x scale must give a zero x axis: checks scale/rotation alignment
	a_zero_scl: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(item.scale_x, ETM_LAT) == 24'sd0) |->
		(result.axis_x_0 == 24'sd0 && result.axis_x_1 == 24'sd0
			&& result.axis_x_2 == 24'sd0))
		else $error("x axis nonzero for zero scale");

endmodule
